// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/mat4m_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mat4m_pkg;

  // Default matrix dimension
  localparam int DimDef = 4;

  // Field widths
  localparam int OpW    = 2;
  localparam int IdxW   = 4;
  localparam int ValW   = 32;
  localparam int FracW  = 16;
  localparam int ProdW  = 2 * ValW;

  // Operation codes
  localparam logic [OpW-1:0] OP_LOAD_L = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_R = 2'd1;
  localparam logic [OpW-1:0] OP_MUL    = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [IdxW-1:0]        elem_index;
    logic signed [ValW-1:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]        out_index;
    logic signed [ValW-1:0] out_value;
    logic                   saturated;
    logic                   last;
  } out_item_t;

  // Sequencer to datapath
  typedef struct packed {
    logic issue;   // memory reads issued this cycle
    logic clear;   // start of a new dot product
  } mac_ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic busy;    // terms still in flight
  } mac_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/mat4m_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mat4m_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mat4m_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mat4m_mac
  import mat4m_pkg::*;
#(
  parameter int Dim = DimDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mac_ctrl_t              ctrl_i,
  input  wire logic [ValW-1:0]        a_i,
  input  wire logic [ValW-1:0]        b_i,
  output mac_stat_t                   stat_o,
  output logic signed [ValW-1:0]      value_o,
  output logic                        sat_o
);

  localparam int AccW = ProdW + $clog2(Dim);

  logic                     rd_vld_q;
  logic                     prod_vld_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  logic signed [AccW-1:0]   acc_d;
  logic signed [AccW-1:0]   shifted;
  logic [AccW-ValW:0]       top_bits;
  logic                     fits;

  // Valid tracking through read and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  // Full-precision product, registered
  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= $signed(a_i) * $signed(b_i);
    end
  end

  // Accumulate the exact sum
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q) begin
      acc_d = acc_q + {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Floor shift, then clip to the 32-bit range
  assign shifted  = acc_q >>> FracW;
  assign top_bits = shifted[AccW-1:ValW-1];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (fits) begin
      value_o = shifted[ValW-1:0];
    end else if (acc_q[AccW-1]) begin
      value_o = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      value_o = {1'b0, {(ValW-1){1'b1}}};
    end
  end

  assign sat_o       = ~fits;
  assign stat_o.busy = rd_vld_q | prod_vld_q;

endmodule

`default_nettype wire

// ----- rtl/core/mat4_multiply.sv -----
// mat4_multiply: DIM x DIM signed Q16.16 matrix product, column-major
// (position = column * DIM + row).
// Input channel (in_valid_i / in_stall_o / in_item_i): op 0 loads one
// element of the left matrix, op 1 one element of the right matrix, op 2
// computes left * right. Loads at a position of DIM*DIM or beyond, and
// op 3, are dropped.
// Output channel (out_valid_o / out_stall_i / out_item_o): a multiply
// emits DIM*DIM elements in position order, last set on the final one;
// each is the floor of the exact dot product over 2^16, clipped to 32 bits
// with saturated set when clipped.
// Each product element is built one dot-product term per cycle, limited
// by the single read port of each matrix memory; the multiply pipeline
// then drains and the element is loaded into the output register.
// in_stall_o is high for the whole run. A stalled output holds its
// element and the sequencer waits on it. Loads are refused during a
// run; only the final element may still wait on the output while
// loads are taken.
// Reset empties the output and returns to idle; matrix contents are
// undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mat4_multiply
  import mat4m_pkg::*;
#(
  parameter int Dim = DimDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int NElem = Dim * Dim;
  localparam int AW    = $clog2(NElem);
  localparam int DW    = $clog2(Dim);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [DW-1:0] k_q, k_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] col_q, col_d;
  logic [AW-1:0] pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  out_item_t     out_q;

  logic          in_xfer;
  logic          idx_ok;
  logic          we_l, we_r;
  logic          emit_go;
  logic          pos_last;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr_l, raddr_r;
  logic [ValW-1:0] rdata_l, rdata_r;

  mac_ctrl_t             mac_ctrl;
  mac_stat_t             mac_stat;
  logic signed [ValW-1:0] mac_value;
  logic                  mac_sat;

  // Input side
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign idx_ok     = (32'(in_item_i.elem_index) < 32'(NElem));
  assign we_l       = in_xfer & idx_ok & (in_item_i.op == OP_LOAD_L);
  assign we_r       = in_xfer & idx_ok & (in_item_i.op == OP_LOAD_R);
  assign waddr      = AW'(in_item_i.elem_index);

  // Operand addresses for the current term
  assign raddr_l = AW'(k_q) * AW'(Dim) + AW'(row_q);
  assign raddr_r = AW'(col_q) * AW'(Dim) + AW'(k_q);

  assign mac_ctrl.issue = (state_q == ST_ISSUE);
  assign mac_ctrl.clear = (state_q == ST_ISSUE) && (k_q == '0);

  mat4m_ram #(.Width(ValW), .Depth(NElem)) u_left (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (waddr),
    .wdata_i (in_item_i.elem_value),
    .re_i    (mac_ctrl.issue),
    .raddr_i (raddr_l),
    .rdata_o (rdata_l)
  );

  mat4m_ram #(.Width(ValW), .Depth(NElem)) u_right (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (waddr),
    .wdata_i (in_item_i.elem_value),
    .re_i    (mac_ctrl.issue),
    .raddr_i (raddr_r),
    .rdata_o (rdata_r)
  );

  mat4m_mac #(.Dim(Dim)) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .a_i     (rdata_l),
    .b_i     (rdata_r),
    .stat_o  (mac_stat),
    .value_o (mac_value),
    .sat_o   (mac_sat)
  );

  // Output slot free this cycle
  assign emit_go  = (state_q == ST_EMIT) && (~out_valid_q || ~out_stall_i);
  assign pos_last = (pos_q == AW'(NElem - 1));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    row_d       = row_q;
    col_d       = col_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_item_i.op == OP_MUL) begin
          state_d = ST_ISSUE;
          k_d     = '0;
          row_d   = '0;
          col_d   = '0;
          pos_d   = '0;
        end
      end
      ST_ISSUE: begin
        if (k_q == DW'(Dim - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!mac_stat.busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          k_d         = '0;
          if (pos_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_ISSUE;
            pos_d   = pos_q + 1'b1;
            if (row_q == DW'(Dim - 1)) begin
              row_d = '0;
              col_d = col_q + 1'b1;
            end else begin
              row_d = row_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      row_q       <= '0;
      col_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      row_q       <= row_d;
      col_q       <= col_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (emit_go) begin
      out_q.out_index <= IdxW'(pos_q);
      out_q.out_value <= mac_value;
      out_q.saturated <= mac_sat;
      out_q.last      <= pos_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `ASSERT_AT(a_mul_starts, clk_i, rst_ni,
    (in_xfer && in_item_i.op == OP_MUL) |=> (state_q == ST_ISSUE), "multiply did not start")
  `ASSERT_NEVER(a_emit_busy, clk_i, rst_ni,
    (state_q == ST_EMIT) && mac_stat.busy, "emit while terms in flight")
  `ASSERT_AT(a_last_idle, clk_i, rst_ni,
    (emit_go && pos_last) |=> (state_q == ST_IDLE && out_valid_q && out_q.last),
    "run did not end on last element")

endmodule

`default_nettype wire

// ----- test/mat4_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of mat4_multiply, keeps its own copy of the two
// operand matrices, and checks every product element against a prediction.
module mat4_checker
  import mat4m_pkg::*;
#(
  parameter int Dim = DimDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_item_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             checked_o
);

  localparam int NumElem = Dim * Dim;
  // four 64-bit products need two extra bits; keep some headroom
  localparam int AccW    = ProdW + 4;
  localparam logic signed [AccW-1:0] ClipHi =
    {{(AccW-ValW+1){1'b0}}, {(ValW-1){1'b1}}};
  localparam logic signed [AccW-1:0] ClipLo =
    {{(AccW-ValW+1){1'b1}}, {(ValW-1){1'b0}}};

  logic signed [ValW-1:0] lhs_q [NumElem];
  logic signed [ValW-1:0] rhs_q [NumElem];
  out_item_t              product_q [$];
  int                     mismatches = 0;
  int                     checked    = 0;

  // Exact dot product, floor-shifted to Q16.16 and clipped to 32 bits
  function automatic out_item_t product_element(input int row, input int col);
    logic signed [AccW-1:0] acc;
    logic signed [AccW-1:0] scaled;
    out_item_t              elem;
    acc = '0;
    for (int k = 0; k < Dim; k++) begin
      acc += lhs_q[k*Dim + row] * rhs_q[col*Dim + k];
    end
    scaled = acc >>> FracW;
    elem.out_index = IdxW'(col*Dim + row);
    elem.last      = (col*Dim + row == NumElem - 1);
    if (scaled > ClipHi) begin
      elem.out_value = ClipHi[ValW-1:0];
      elem.saturated = 1'b1;
    end else if (scaled < ClipLo) begin
      elem.out_value = ClipLo[ValW-1:0];
      elem.saturated = 1'b1;
    end else begin
      elem.out_value = scaled[ValW-1:0];
      elem.saturated = 1'b0;
    end
    return elem;
  endfunction

  task automatic check_field(input string name, input logic [ValW-1:0] want,
                             input logic [ValW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Output side first: a product can never stem from an input of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      product_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (product_q.size() == 0) begin
          $display("%0t ns: unexpected product element, expected none, actual %h",
                   $time, out_item_i);
          mismatches++;
        end else begin
          want = product_q.pop_front();
          check_field("out_index", ValW'(want.out_index), ValW'(out_item_i.out_index));
          check_field("out_value", want.out_value, out_item_i.out_value);
          check_field("saturated", ValW'(want.saturated), ValW'(out_item_i.saturated));
          check_field("last", ValW'(want.last), ValW'(out_item_i.last));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (in_item_i.op)
          OP_LOAD_L: begin
            if (in_item_i.elem_index < NumElem) lhs_q[in_item_i.elem_index] = in_item_i.elem_value;
          end
          OP_LOAD_R: begin
            if (in_item_i.elem_index < NumElem) rhs_q[in_item_i.elem_index] = in_item_i.elem_value;
          end
          OP_MUL: begin
            for (int c = 0; c < Dim; c++) begin
              for (int r = 0; r < Dim; r++) begin
                product_q.push_back(product_element(r, c));
              end
            end
          end
          default: ;  // unused op code is dropped
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= product_q.size();
    checked_o    <= checked;
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import mat4m_pkg::*;

  localparam int Dim           = DimDef;
  localparam int NumElem       = Dim * Dim;
  localparam int ClkPeriod     = 20;
  localparam int RandItems     = 172;
  localparam int DrainCycles   = 4 * (Dim + 5);
  localparam int TimeoutCycles = 500_000;
  localparam logic [OpW-1:0] OpUnused = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int pending;
  int checked;
  int gap_pct   = 0;
  int stall_pct = 0;
  int n_load    = 0;
  int n_mul     = 0;

  always #(ClkPeriod / 2) clk = ~clk;

  mat4_multiply #(.Dim(Dim)) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  mat4_checker #(.Dim(Dim)) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Receiver back-pressure, rate set per phase
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Mostly small Q16.16 values so products stay in range, plus extremes
  // and full-width noise to hit saturation and every bit
  function automatic logic [ValW-1:0] draw_element();
    case ($urandom_range(0, 9))
      0, 1: draw_element = $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0:       draw_element = 32'h8000_0000;
          1:       draw_element = 32'h7FFF_FFFF;
          2:       draw_element = 32'h0000_0000;
          3:       draw_element = 32'hFFFF_FFFF;
          4:       draw_element = 32'h0001_0000;
          default: draw_element = 32'hFFFF_0000;
        endcase
      end
      default: draw_element = $urandom_range(0, 2**18 - 1) - 2**17;
    endcase
  endfunction

  // One transfer on the input channel, with random sender gaps ahead of it
  task automatic send_item(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                           input logic [ValW-1:0] val);
    in_item_t item;
    item.op         = op;
    item.elem_index = idx;
    item.elem_value = val;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    if (op == OP_MUL) n_mul++;
    else if (op != OpUnused) n_load++;
  endtask

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int base;
    int nloads;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both matrices: all most-negative, right column 0 most-positive.
    // Column 0 clips low, the rest clip high.
    for (int i = 0; i < NumElem; i++) begin
      send_item(OP_LOAD_L, IdxW'(i), 32'h8000_0000);
      send_item(OP_LOAD_R, IdxW'(i), (i < Dim) ? 32'h7FFF_FFFF : 32'h8000_0000);
    end
    send_item(OP_MUL, 4'h0, 32'h0000_0000);
    // unused op must leave the matrices alone
    send_item(OpUnused, 4'hF, 32'hFFFF_FFFF);
    // left row 0 = -1 ulp, right column 1 = +1 ulp: floor of a small negative
    for (int k = 0; k < Dim; k++) send_item(OP_LOAD_L, IdxW'(k*Dim), 32'hFFFF_FFFF);
    for (int k = 0; k < Dim; k++) send_item(OP_LOAD_R, IdxW'(Dim + k), 32'h0000_0001);
    // right column 3 zero
    for (int k = 0; k < Dim; k++) send_item(OP_LOAD_R, IdxW'(3*Dim + k), 32'h0000_0000);
    // multiply ignores its index and value
    send_item(OP_MUL, 4'hF, 32'hFFFF_FFFF);

    // Random load runs ended by a multiply, across four idling phases
    base = n_load + n_mul;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct <= 0;  stall_pct <= 0;  end
        1:       begin gap_pct <= 46; stall_pct <= 0;  end
        2:       begin gap_pct <= 0;  stall_pct <= 46; end
        default: begin gap_pct <= 36; stall_pct <= 36; end
      endcase
      while (n_load + n_mul - base < (ph + 1) * RandItems / 4) begin
        nloads = $urandom_range(0, 7);
        for (int j = 0; j < nloads; j++) begin
          if ($urandom_range(0, 19) == 0) begin
            send_item(OpUnused, IdxW'($urandom()), $urandom());
          end
          send_item($urandom_range(0, 1) ? OP_LOAD_R : OP_LOAD_L,
                    IdxW'($urandom_range(0, NumElem - 1)), draw_element());
        end
        send_item(OP_MUL, IdxW'($urandom()), $urandom());
      end
    end
    in_valid <= 1'b0;

    // drain, then watch a little longer for stray elements
    do @(posedge clk); while (pending != 0);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d element loads and %0d multiplies, %0d product elements compared,",
             n_load, n_mul, checked);
    $display("with no idling, sender gaps, receiver stalls and both combined.");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
